@@ rtl/entity_id_allocator_unit_macros.svh @@
// Assertion helpers used by the allocator back end (eia_back).
`ifndef ENTITY_ID_ALLOCATOR_UNIT_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EIA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eia assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eia assertion failed");

`endif

@@ rtl/eia_pkg.sv @@
`default_nettype none

package eia_pkg;

  localparam int MAX_ENTITIES = 64;
  localparam int NUM_TYPES    = 8;

  localparam int OPCODE_W = 2;
  localparam int ID_W     = 6;
  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_ADD     = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DUP     = 2'd2,
    ST_FULL    = 2'd3
  } st_t;

  // Classified request as handed from the front end to the back end.
  typedef struct packed {
    op_t               kind;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ctype;
    logic              id_ok;
    logic              type_ok;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/eia_req_if.sv @@
`default_nettype none

interface eia_req_if
  import eia_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_W-1:0]     entity_id;
  logic [TYPE_W-1:0]   component_type;

  modport source (output valid, output opcode, output entity_id, output component_type,
                  input ready);
  modport sink   (input valid, input opcode, input entity_id, input component_type,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/eia_rsp_if.sv @@
`default_nettype none

interface eia_rsp_if
  import eia_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     new_id;

  modport source (output valid, output status, output new_id, input ready);
  modport sink   (input valid, input status, input new_id, output ready);
endinterface

`default_nettype wire

@@ rtl/eia_ram.sv @@
`default_nettype none

module eia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/eia_front.sv @@
`default_nettype none

module eia_front
  import eia_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  eia_req_if.sink   req,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output cmd_t      cmd
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              incoming;
  logic              push;
  logic              pop;

  // Range checks are done here so the back end only looks at flags.
  always_comb begin
    incoming.kind    = op_t'(req.opcode);
    incoming.id      = req.entity_id;
    incoming.ctype   = req.component_type;
    incoming.id_ok   = 32'(req.entity_id) < 32'(MAX_ENTITIES);
    incoming.type_ok = 32'(req.component_type) < 32'(NUM_TYPES);
  end

  assign req.ready = count != QCNT_W'(QDEPTH);
  assign push      = req.valid && req.ready;
  assign cmd_valid = count != '0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q[wr_ptr] <= incoming;
        wr_ptr    <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/eia_back.sv @@
`default_nettype none
`include "entity_id_allocator_unit_macros.svh"

module eia_back
  import eia_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  eia_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);
  localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                  state;
  cmd_t                    cur;
  logic [CNT_W-1:0]        stack_count;
  logic [CNT_W-1:0]        next_fresh;
  logic                    rsp_valid;
  st_t                     rsp_status;
  logic [ID_W-1:0]         rsp_new_id;

  logic                 out_free;
  logic                 take;
  logic [IDX_W-1:0]     cur_idx;
  logic [IDX_W-1:0]     head_idx;
  logic [IDX_W-1:0]     fresh_idx;
  logic [CNT_W-1:0]     stack_top;
  logic                 cur_issued;
  logic                 cur_live;
  logic                 stack_nonempty;
  logic                 fresh_end;
  logic [NUM_TYPES-1:0] type_mask;

  logic                 t_we;
  logic [IDX_W-1:0]     t_waddr;
  logic [NUM_TYPES-1:0] t_wdata;
  logic [NUM_TYPES-1:0] t_rdata;
  logic                 s_we;
  logic [IDX_W-1:0]     s_rdata;

  eia_ram #(.WIDTH(NUM_TYPES), .DEPTH(MAX_ENTITIES)) u_type_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (head_idx),
    .rdata (t_rdata)
  );

  eia_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTITIES)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (stack_count[IDX_W-1:0]),
    .wdata (cur_idx),
    .raddr (stack_top[IDX_W-1:0]),
    .rdata (s_rdata)
  );

  assign out_free       = !rsp_valid || rsp.ready;
  assign cmd_ready      = (state == S_IDLE) && out_free;
  assign take           = cmd_valid && cmd_ready;
  assign cur_idx        = IDX_W'(cur.id);
  assign head_idx       = IDX_W'(cmd.id);
  assign fresh_idx      = next_fresh[IDX_W-1:0];
  assign stack_top      = stack_count - CNT_W'(1);
  assign stack_nonempty = stack_count != '0;
  assign fresh_end      = next_fresh == CNT_W'(MAX_ENTITIES);
  assign type_mask      = NUM_TYPES'(1) << cur.ctype;

  // Entries at or above the fresh counter have never been written. Below it, an
  // identifier is live exactly when the basic type bit of its type word is set,
  // since create writes that bit and destroy clears the whole word.
  assign cur_issued     = CNT_W'(cur_idx) < next_fresh;
  assign cur_live       = cur.id_ok && cur_issued && t_rdata[0];

  // Memory writes happen in the execute state; reads are issued at take.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = cur_idx;
    t_wdata = t_rdata | type_mask;
    s_we    = 1'b0;
    unique case (state)
      S_EXEC: begin
        unique case (cur.kind)
          OP_CREATE: begin
            if (stack_nonempty) begin
              t_we    = 1'b1;
              t_waddr = s_rdata;
              t_wdata = NUM_TYPES'(1);
            end else if (!fresh_end) begin
              t_we    = 1'b1;
              t_waddr = fresh_idx;
              t_wdata = NUM_TYPES'(1);
            end
          end
          OP_DESTROY: begin
            t_we    = cur_live;
            t_wdata = '0;
            s_we    = cur_live && (stack_count < CNT_W'(MAX_ENTITIES));
          end
          OP_ADD: begin
            t_we = cur_live && cur.type_ok && ((t_rdata & type_mask) == '0);
          end
          OP_NONE: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_count <= '0;
      next_fresh  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            cur   <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          rsp_valid  <= 1'b1;
          rsp_new_id <= '0;
          state      <= S_IDLE;
          unique case (cur.kind)
            OP_CREATE: begin
              // Every live identifier lies below the fresh counter, so the
              // identifier at the counter is always free and needs no search.
              if (stack_nonempty) begin
                stack_count <= stack_top;
                rsp_status  <= ST_OK;
                rsp_new_id  <= ID_W'(s_rdata);
              end else if (fresh_end) begin
                rsp_status <= ST_FULL;
              end else begin
                next_fresh <= next_fresh + CNT_W'(1);
                rsp_status <= ST_OK;
                rsp_new_id <= ID_W'(fresh_idx);
              end
            end
            OP_DESTROY: begin
              if (cur_live) begin
                rsp_status <= ST_OK;
                if (stack_count < CNT_W'(MAX_ENTITIES)) begin
                  stack_count <= stack_count + CNT_W'(1);
                end
              end else begin
                rsp_status <= ST_INVALID;
              end
            end
            OP_ADD: begin
              if (!cur_live || !cur.type_ok) begin
                rsp_status <= ST_INVALID;
              end else if ((t_rdata & type_mask) != '0) begin
                rsp_status <= ST_DUP;
              end else begin
                rsp_status <= ST_OK;
              end
            end
            OP_NONE: begin
              rsp_status <= ST_INVALID;
            end
            default: begin
              rsp_status <= ST_INVALID;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.new_id = rsp_new_id;

  // The result register is free whenever a command is in flight.
  `EIA_ASSERT_IMPLIES(a_busy_out_empty, clk, rst, state != S_IDLE, !rsp_valid)
  `EIA_ASSERT_IMPLIES(a_stack_bound, clk, rst, 1'b1, stack_count <= CNT_W'(MAX_ENTITIES))
  `EIA_ASSERT_IMPLIES(a_fresh_bound, clk, rst, 1'b1, next_fresh <= CNT_W'(MAX_ENTITIES))
  `EIA_ASSERT_IMPLIES(a_fail_zero_id, clk, rst, rsp_valid && rsp_status != ST_OK, rsp_new_id == '0)
  `EIA_ASSERT_NEXT(a_take_exec, clk, rst, take, state == S_EXEC)

endmodule

`default_nettype wire

@@ rtl/entity_id_allocator_unit.sv @@
// A result beat is presented after the request passes the front end's queue, the back
// end's command register and its result register; every request kind, create included,
// takes that path. The back end takes no new request until the current one
// has run its take/execute pair around the registered type and free-stack memory reads.
// Reset (synchronous, rst high) clears the counters, request queue and result register;
// type entries at or above the fresh counter count as free, so no clearing pass is run.
`default_nettype none

module entity_id_allocator_unit
  import eia_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  eia_req_if.sink   req,
  eia_rsp_if.source rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  eia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  eia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
module tb;
  import eia_pkg::*;

  localparam int MAX_IDS      = 64;
  localparam int TYPE_COUNT   = 8;
  localparam int SCRIPT_LEN   = 24;
  localparam int RANDOM_BEATS = 600;
  localparam int PHASE_LEN    = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    st_t             status;
    logic [ID_W-1:0] new_id;
  } outcome_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ct;
    logic              lit;
    st_t               st;
    logic [ID_W-1:0]   nid;
  } script_row_t;

  logic clk;
  logic rst;

  eia_req_if req_ch();
  eia_rsp_if rsp_ch();

  entity_id_allocator_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the allocator state.
  bit [MAX_IDS-1:0]    live_mask = '0;
  logic [TYPE_COUNT-1:0] types_held [MAX_IDS];
  logic [ID_W-1:0]     freed_ids [MAX_IDS];
  int                  freed_depth = 0;
  int                  fresh_ptr = 0;

  outcome_t pending_results[$];
  outcome_t head_result;
  int       fail_count = 0;
  int       beats_sent = 0;
  int       results_seen = 0;
  int       full_refusals = 0;
  int       dup_answers = 0;
  int       quiet_cycles = 0;
  bit       idle_on = 1'b1;

  // Rows with lit set carry the answer that can be read off directly; the rest
  // are checked against the shadow state.
  script_row_t script [0:SCRIPT_LEN-1] = '{
    '{OP_CREATE,  6'd0,  3'd0, 1'b1, ST_OK,      6'd0},
    '{OP_CREATE,  6'd63, 3'd7, 1'b1, ST_OK,      6'd1},
    '{OP_ADD,     6'd0,  3'd0, 1'b1, ST_DUP,     6'd0},
    '{OP_ADD,     6'd0,  3'd7, 1'b1, ST_OK,      6'd0},
    '{OP_ADD,     6'd0,  3'd7, 1'b1, ST_DUP,     6'd0},
    '{OP_ADD,     6'd63, 3'd1, 1'b1, ST_INVALID, 6'd0},
    '{OP_DESTROY, 6'd63, 3'd0, 1'b1, ST_INVALID, 6'd0},
    '{OP_DESTROY, 6'd1,  3'd0, 1'b1, ST_OK,      6'd0},
    '{OP_DESTROY, 6'd1,  3'd0, 1'b1, ST_INVALID, 6'd0},
    '{OP_ADD,     6'd1,  3'd3, 1'b1, ST_INVALID, 6'd0},
    '{OP_CREATE,  6'd0,  3'd0, 1'b1, ST_OK,      6'd1},
    '{OP_ADD,     6'd1,  3'd0, 1'b1, ST_DUP,     6'd0},
    '{OP_NONE,    6'd63, 3'd7, 1'b1, ST_INVALID, 6'd0},
    '{OP_NONE,    6'd0,  3'd0, 1'b1, ST_INVALID, 6'd0},
    '{OP_DESTROY, 6'd0,  3'd0, 1'b1, ST_OK,      6'd0},
    '{OP_DESTROY, 6'd1,  3'd0, 1'b1, ST_OK,      6'd0},
    '{OP_CREATE,  6'd0,  3'd0, 1'b1, ST_OK,      6'd1},
    '{OP_CREATE,  6'd0,  3'd0, 1'b1, ST_OK,      6'd0},
    '{OP_CREATE,  6'd0,  3'd0, 1'b1, ST_OK,      6'd2},
    '{OP_ADD,     6'd2,  3'd5, 1'b0, ST_OK,      6'd0},
    '{OP_ADD,     6'd2,  3'd5, 1'b0, ST_OK,      6'd0},
    '{OP_ADD,     6'd0,  3'd7, 1'b1, ST_OK,      6'd0},
    '{OP_DESTROY, 6'd2,  3'd0, 1'b0, ST_OK,      6'd0},
    '{OP_CREATE,  6'd0,  3'd0, 1'b0, ST_OK,      6'd0}
  };

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic outcome_t predict_outcome(input op_t op, input logic [ID_W-1:0] id,
                                               input logic [TYPE_W-1:0] ct);
    outcome_t o;
    int pick;
    o.status = ST_OK;
    o.new_id = '0;
    case (op)
      OP_CREATE: begin
        if (freed_depth > 0) begin
          freed_depth--;
          pick = freed_ids[freed_depth];
        end else begin
          while (fresh_ptr < MAX_IDS && live_mask[fresh_ptr]) fresh_ptr++;
          if (fresh_ptr >= MAX_IDS) begin
            pick = -1;
          end else begin
            pick = fresh_ptr;
            fresh_ptr++;
          end
        end
        if (pick < 0) begin
          o.status = ST_FULL;
        end else begin
          live_mask[pick] = 1'b1;
          types_held[pick] = TYPE_COUNT'(1);
          o.new_id = ID_W'(pick);
        end
      end
      OP_DESTROY: begin
        if (!live_mask[id]) begin
          o.status = ST_INVALID;
        end else begin
          live_mask[id] = 1'b0;
          types_held[id] = '0;
          if (freed_depth < MAX_IDS) begin
            freed_ids[freed_depth] = id;
            freed_depth++;
          end
        end
      end
      OP_ADD: begin
        if (!live_mask[id]) o.status = ST_INVALID;
        else if (types_held[id][ct]) o.status = ST_DUP;
        else types_held[id][ct] = 1'b1;
      end
      default: o.status = ST_INVALID;
    endcase
    return o;
  endfunction

  // Mostly a live identifier, found by walking up from a random point.
  function automatic logic [ID_W-1:0] pick_live_id();
    int origin;
    int k;
    origin = $urandom_range(MAX_IDS - 1);
    for (k = 0; k < MAX_IDS; k++) begin
      if (live_mask[(origin + k) % MAX_IDS]) return ID_W'((origin + k) % MAX_IDS);
    end
    return ID_W'(origin);
  endfunction

  task automatic send_beat(input op_t op, input logic [ID_W-1:0] id,
                           input logic [TYPE_W-1:0] ct, input bit use_lit,
                           input outcome_t lit);
    outcome_t predicted;
    while (idle_on && $urandom_range(99) < 32) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.entity_id <= id;
    req_ch.component_type <= ct;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_outcome(op, id, ct);
    pending_results.insert(pending_results.size(), use_lit ? lit : predicted);
    beats_sent++;
    if (predicted.status == ST_FULL) full_refusals++;
    if (predicted.status == ST_DUP) dup_answers++;
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    outcome_t lit_row;
    op_t      op;
    int       roll;
    bit       grow;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ct;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_NONE;
    req_ch.entity_id <= '0;
    req_ch.component_type <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      lit_row.status = script[r].st;
      lit_row.new_id = script[r].nid;
      send_beat(script[r].op, script[r].id, script[r].ct, script[r].lit, lit_row);
    end
    wait_for_results();

    // Grow phases fill the table until creates are refused; shrink phases
    // drain it again so the free stack gets deep.
    lit_row = '0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      idle_on = !(n >= 200 && n < 320);
      if (n == 400) wait_for_results();
      grow = ((n / PHASE_LEN) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 4) op = OP_NONE;
      else if (roll < (grow ? 66 : 24)) op = OP_CREATE;
      else if (roll < (grow ? 80 : 72)) op = OP_DESTROY;
      else op = OP_ADD;
      ct = TYPE_W'($urandom_range(TYPE_COUNT - 1));
      if ((op == OP_DESTROY || op == OP_ADD) && $urandom_range(99) < 80) id = pick_live_id();
      else id = ID_W'($urandom_range(MAX_IDS - 1));
      send_beat(op, id, ct, 1'b0, lit_row);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d request beats sent, %0d result beats checked", beats_sent, results_seen);
    $display("tb: %0d creates refused with the table full, %0d duplicate adds",
             full_refusals, dup_answers);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: status %0d new_id %0d", rsp_ch.status, rsp_ch.new_id);
          fail_count++;
        end else begin
          head_result = pending_results.pop_front();
          results_seen++;
          if (rsp_ch.status !== head_result.status) begin
            $error("status: expected %0d, got %0d", head_result.status, rsp_ch.status);
            fail_count++;
          end
          if (rsp_ch.new_id !== head_result.new_id) begin
            $error("new_id: expected %0d, got %0d", head_result.new_id, rsp_ch.new_id);
            fail_count++;
          end
        end
      end
      rsp_ch.ready <= !(idle_on && $urandom_range(99) < 32);
    end
  end

  // Ends a hung run: no beat on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule
